// ===== rtl/double_ended_queue_with_search_defines.svh =====
// ----------------------------------------------------------------------------
// Double-ended queue with search: assertion macros
// Shared macros for the port-level checks of the deque.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_WITH_SEARCH_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SEARCH_DEFINES_SVH

// Check a condition that must hold in the same cycle.
`define DEQ_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Check that a trigger is followed by a consequence in the next cycle.
`define DEQ_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// Deque package
// Operation and status codes, controller states and the command and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package deq_pkg;

	typedef logic [2:0] kind_t;

	localparam kind_t KIND_PUSH_FRONT = 3'd0;
	localparam kind_t KIND_PUSH_BACK  = 3'd1;
	localparam kind_t KIND_POP_FRONT  = 3'd2;
	localparam kind_t KIND_POP_BACK   = 3'd3;
	localparam kind_t KIND_SEARCH     = 3'd4;
	localparam kind_t KIND_WALK_FWD   = 3'd5;
	localparam kind_t KIND_WALK_BACK  = 3'd6;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_EMPTY    = 2'd1;
	localparam status_t ST_FULL     = 2'd2;
	localparam status_t ST_NOTFOUND = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic    load;     // latch request fields, rewind scan index
		logic    rd;       // read entry at scan index, advance index
		logic    push;
		logic    pop;
		logic    emit;     // register one result
		status_t status;
		logic    last;
		logic    use_data; // result carries the read word
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		kind_t kind;
		logic  empty;
		logic  full;
		logic  match;   // word just read equals the search key
		logic  rd_last; // word just read is the final held entry
	} dp_stat_t;

	function automatic logic is_nan(input logic [31:0] w);
		return (w[30:23] == 8'hFF) && (w[22:0] != 23'd0);
	endfunction

	function automatic logic ieee_eq(input logic [31:0] a, input logic [31:0] b);
		if (is_nan(a) || is_nan(b))
			return 1'b0;
		if (((a | b) & 32'h7FFF_FFFF) == 32'd0)
			return 1'b1;
		return a == b;
	endfunction

endpackage

// ===== rtl/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Deque controller
// Decodes a request, then issues reads, updates and result strobes.
// ----------------------------------------------------------------------------
module deq_ctrl import deq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output logic     busy,
	output dp_cmd_t  cmd
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start)
					state_nxt = S_DECODE;
			end
			S_DECODE: begin
				state_nxt = S_IDLE;
				unique case (stat.kind) inside
					KIND_POP_FRONT, KIND_POP_BACK, KIND_SEARCH,
					KIND_WALK_FWD, KIND_WALK_BACK: begin
						if (!stat.empty)
							state_nxt = S_SCAN;
					end
					default: ;
				endcase
			end
			S_SCAN: begin
				state_nxt = S_IDLE;
				unique case (stat.kind) inside
					KIND_SEARCH: begin
						if (!stat.match && !stat.rd_last)
							state_nxt = S_SCAN;
					end
					KIND_WALK_FWD, KIND_WALK_BACK: begin
						if (!stat.rd_last)
							state_nxt = S_SCAN;
					end
					default: ;
				endcase
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				cmd.load = start;
			end
			S_DECODE: begin
				unique case (stat.kind) inside
					KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
						cmd.emit   = 1'b1;
						cmd.last   = 1'b1;
						cmd.status = stat.full ? ST_FULL : ST_OK;
						cmd.push   = !stat.full;
					end
					KIND_POP_FRONT, KIND_POP_BACK, KIND_WALK_FWD, KIND_WALK_BACK: begin
						if (stat.empty) begin
							cmd.emit   = 1'b1;
							cmd.last   = 1'b1;
							cmd.status = ST_EMPTY;
						end else begin
							cmd.rd = 1'b1;
						end
					end
					KIND_SEARCH: begin
						if (stat.empty) begin
							cmd.emit   = 1'b1;
							cmd.last   = 1'b1;
							cmd.status = ST_NOTFOUND;
						end else begin
							cmd.rd = 1'b1;
						end
					end
					default: ;
				endcase
			end
			S_SCAN: begin
				unique case (stat.kind) inside
					KIND_POP_FRONT, KIND_POP_BACK: begin
						cmd.emit     = 1'b1;
						cmd.last     = 1'b1;
						cmd.status   = ST_OK;
						cmd.use_data = 1'b1;
						cmd.pop      = 1'b1;
					end
					KIND_SEARCH: begin
						if (stat.match) begin
							cmd.emit   = 1'b1;
							cmd.last   = 1'b1;
							cmd.status = ST_OK;
						end else if (stat.rd_last) begin
							cmd.emit   = 1'b1;
							cmd.last   = 1'b1;
							cmd.status = ST_NOTFOUND;
						end else begin
							cmd.rd = 1'b1;
						end
					end
					KIND_WALK_FWD, KIND_WALK_BACK: begin
						cmd.emit     = 1'b1;
						cmd.last     = stat.rd_last;
						cmd.status   = ST_OK;
						cmd.use_data = 1'b1;
						cmd.rd       = !stat.rd_last;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/deq_dpath.sv =====
// ----------------------------------------------------------------------------
// Deque datapath
// Ring storage, front pointer, fill count, scan index and result registers.
// ----------------------------------------------------------------------------
module deq_dpath import deq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [2:0]  kind,
	input  logic [31:0] value_in,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] value_out,
	output logic        last
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W:0] DEPTH_X = (IDX_W + 1)'(DEPTH);
	localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	logic [31:0] mem [DEPTH];

	kind_t             kind_q;
	logic [31:0]       val_q;
	logic [IDX_W-1:0]  front_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  rd_idx_q;
	logic [31:0]       rd_data_s1;
	logic              rd_last_s1;
	logic              res_valid_q;
	status_t           res_status_q;
	logic [31:0]       res_value_q;
	logic              res_last_q;

	logic              backward;
	logic [CNT_W-1:0]  rd_off;
	logic [IDX_W:0]    rd_sum;
	logic [IDX_W-1:0]  rd_addr;
	logic [IDX_W:0]    tail_sum;
	logic [IDX_W-1:0]  tail_addr;
	logic [IDX_W-1:0]  front_dec;
	logic [IDX_W-1:0]  front_inc;
	logic [IDX_W-1:0]  wr_addr;

	always_comb begin
		backward  = (kind_q == KIND_POP_BACK) || (kind_q == KIND_WALK_BACK);
		rd_off    = backward ? (count_q - CNT_W'(1) - rd_idx_q) : rd_idx_q;
		rd_sum    = {1'b0, front_q} + (IDX_W + 1)'(rd_off);
		rd_addr   = (rd_sum >= DEPTH_X) ? IDX_W'(rd_sum - DEPTH_X) : rd_sum[IDX_W-1:0];
		tail_sum  = {1'b0, front_q} + (IDX_W + 1)'(count_q);
		tail_addr = (tail_sum >= DEPTH_X) ? IDX_W'(tail_sum - DEPTH_X)
			: tail_sum[IDX_W-1:0];
		front_dec = (front_q == '0) ? TOP_IDX : front_q - IDX_W'(1);
		front_inc = (front_q == TOP_IDX) ? '0 : front_q + IDX_W'(1);
		wr_addr   = (kind_q == KIND_PUSH_FRONT) ? front_dec : tail_addr;
	end

	always_comb begin
		stat.kind    = kind_q;
		stat.empty   = (count_q == '0);
		stat.full    = (count_q == DEPTH_C);
		stat.match   = ieee_eq(rd_data_s1, val_q);
		stat.rd_last = rd_last_s1;
	end

	// storage: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.push)
			mem[wr_addr] <= val_q;
		if (cmd.rd) begin
			rd_data_s1 <= mem[rd_addr];
			rd_last_s1 <= (rd_idx_q == count_q - CNT_W'(1));
		end
		if (cmd.load) begin
			kind_q <= kind;
			val_q  <= value_in;
		end
		if (cmd.emit) begin
			res_status_q <= cmd.status;
			res_value_q  <= cmd.use_data ? rd_data_s1 : 32'd0;
			res_last_q   <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			count_q     <= '0;
			rd_idx_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= cmd.emit;
			if (cmd.load)
				rd_idx_q <= '0;
			else if (cmd.rd)
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			if (cmd.push) begin
				count_q <= count_q + CNT_W'(1);
				if (kind_q == KIND_PUSH_FRONT)
					front_q <= front_dec;
			end else if (cmd.pop) begin
				count_q <= count_q - CNT_W'(1);
				if (kind_q == KIND_POP_FRONT)
					front_q <= front_inc;
			end
		end
	end

	assign done      = res_valid_q;
	assign status    = res_status_q;
	assign value_out = res_value_q;
	assign last      = res_last_q;

endmodule

// ===== rtl/double_ended_queue_with_search.sv =====
// Push and empty/full cases give their result from the decode state; done is registered from it.
// Pop reads in the decode state and gives its result from the scan state; search and walk
// scan one held entry per cycle. A new request is taken only while busy is low, once the
// previous request has given its last result.
// Results cannot be stalled; done marks each one for one cycle.
// Reset (arst_n low) empties the queue and drops any request in progress.
// ----------------------------------------------------------------------------
// Double-ended queue with search
// Ring-buffer deque of 32-bit words with push, pop, search and traversal.
// ----------------------------------------------------------------------------
module double_ended_queue_with_search import deq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  logic [31:0] value_in,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] value_out,
	output logic        last
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	deq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	deq_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.kind      (kind),
		.value_in  (value_in),
		.cmd       (cmd),
		.stat      (stat),
		.done      (done),
		.status    (status),
		.value_out (value_out),
		.last      (last)
	);

endmodule

// ===== rtl/deq_checker.sv =====
// ----------------------------------------------------------------------------
// Deque port checker
// Port-level checks on request acceptance and result sequencing.
// ----------------------------------------------------------------------------
`include "double_ended_queue_with_search_defines.svh"

module deq_checker import deq_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [2:0]  kind,
	input logic        done,
	input logic [1:0]  status,
	input logic [31:0] value_out,
	input logic        last
);

	`DEQ_ASSERT_NEXT(a_take_busy, start && !busy, busy, "accepted request did not raise busy")
	`DEQ_ASSERT_NEXT(a_walk_cont, done && !last, done, "result sequence broken before last")
	`DEQ_ASSERT(a_fail_zero, !done || status == ST_OK || (last && value_out == 32'd0), "failed request result not final or not zero")
	`DEQ_ASSERT_NEXT(a_push_resp, start && !busy && (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK), ##1 (done && last), "push result missing")

endmodule

bind double_ended_queue_with_search deq_checker u_deq_checker (.*);
